// ===== design/ign3_pkg.sv =====
// Shared types and constants of the 3D gradient noise core.
`default_nettype none
package ign3_pkg;

  localparam int unsigned TblAw      = 8;
  localparam int unsigned TblDepth   = 256;
  localparam int unsigned NumCopies  = 7;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned SumW       = 33;
  localparam int unsigned OffW       = 24;
  localparam int unsigned CoordW     = 32;
  localparam int unsigned NoiseW     = 18;
  localparam int          NoiseMax   = 131071;
  localparam int          NoiseMin   = -131072;

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_EVAL  = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    CFG_OFFSET_X = 2'd0,
    CFG_OFFSET_Y = 2'd1,
    CFG_OFFSET_Z = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    mode_e                     mode;
    logic [TblAw-1:0]          tbl_idx;
    logic [TblAw-1:0]          tbl_val;
    logic [2:0][SumW-1:0]      sum;
  } item_t;

endpackage
`default_nettype wire

// ===== design/ign3_front.sv =====
// Front end: offset registers, beat acceptance and coordinate offset add.
`default_nettype none
module ign3_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  input  wire logic [1:0]                  cfg_index_i,
  input  wire logic [ign3_pkg::OffW-1:0]   cfg_data_i,
  input  wire logic                        s_valid_i,
  output logic                             s_ready_o,
  // tbl_idx[7:0], tbl_val[15:8], coord_x[47:16], coord_y[79:48], coord_z[111:80]
  input  wire logic [111:0]                s_data_i,
  input  wire logic                        s_user_i,
  output ign3_pkg::item_t                  item_o,
  output logic                             item_vld_o,
  input  wire logic                        item_rdy_i
);
  import ign3_pkg::*;

  logic [OffW-1:0] off_q [3];
  item_t           item_q;
  logic            vld_q;
  logic            take;
  logic [CoordW-1:0] coord [3];

  assign s_ready_o  = !vld_q || item_rdy_i;
  assign take       = s_valid_i && s_ready_o;
  assign item_o     = item_q;
  assign item_vld_o = vld_q;

  assign coord[0] = s_data_i[47:16];
  assign coord[1] = s_data_i[79:48];
  assign coord[2] = s_data_i[111:80];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q[0] <= '0;
      off_q[1] <= '0;
      off_q[2] <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_OFFSET_X: off_q[0] <= cfg_data_i;
        CFG_OFFSET_Y: off_q[1] <= cfg_data_i;
        CFG_OFFSET_Z: off_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (s_ready_o) begin
      vld_q <= s_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.mode    <= mode_e'(s_user_i);
      item_q.tbl_idx <= s_data_i[7:0];
      item_q.tbl_val <= s_data_i[15:8];
      for (int k = 0; k < 3; k++) begin
        item_q.sum[k] <= $unsigned(SumW'($signed(coord[k]))) + SumW'(off_q[k]);
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/ign3_fifo.sv =====
// Two-entry queue between front end and back end.
`default_nettype none
module ign3_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  ign3_pkg::item_t       in_item_i,
  input  wire logic             in_vld_i,
  output logic                  in_rdy_o,
  output ign3_pkg::item_t       out_item_o,
  output logic                  out_vld_o,
  input  wire logic             out_pop_i
);
  import ign3_pkg::*;

  item_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q;
  logic [QueuePtrW-1:0] rd_ptr_q;
  logic [QueuePtrW:0]   cnt_q;
  logic                 push;

  assign in_rdy_o   = cnt_q != (QueuePtrW + 1)'(QueueDepth);
  assign out_vld_o  = cnt_q != '0;
  assign out_item_o = mem_q[rd_ptr_q];
  assign push       = in_vld_i && in_rdy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (out_pop_i) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !out_pop_i) cnt_q <= cnt_q + 1'b1;
      else if (!push && out_pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= in_item_i;
  end

endmodule
`default_nettype wire

// ===== design/ign3_back.sv =====
// Back end: permutation table copies, hash chain, fade, gradients and blend pipeline.
`default_nettype none
module ign3_back #(
  parameter int unsigned FracBits = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  ign3_pkg::item_t                   item_i,
  input  wire logic                         item_vld_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [ign3_pkg::NoiseW-1:0]       out_data_o
);
  import ign3_pkg::*;

  localparam int unsigned VW = FracBits + 5;
  localparam int unsigned PW = 2 * VW;
  localparam logic signed [VW-1:0] OneV     = VW'(1) << FracBits;
  localparam logic signed [VW-1:0] TenV     = VW'(10) << FracBits;
  localparam logic signed [VW-1:0] FifteenV = VW'(15) << FracBits;
  localparam logic signed [PW-1:0] HalfP    = PW'(1) << (FracBits - 1);

  function automatic logic signed [VW-1:0] rmul(input logic signed [VW-1:0] a,
                                               input logic signed [VW-1:0] b);
    logic signed [PW-1:0] p;
    p = (PW'(a) * PW'(b) + HalfP) >>> FracBits;
    return p[VW-1:0];
  endfunction

  function automatic logic signed [VW-1:0] blend(input logic signed [VW-1:0] w,
                                                input logic signed [VW-1:0] a,
                                                input logic signed [VW-1:0] b);
    return a + rmul(w, b - a);
  endfunction

  function automatic logic signed [VW-1:0] grad(input logic [TblAw-1:0] h,
                                               input logic signed [VW-1:0] x,
                                               input logic signed [VW-1:0] y,
                                               input logic signed [VW-1:0] z);
    logic [3:0]             k;
    logic signed [VW-1:0]   u;
    logic signed [VW-1:0]   v;
    k = h[3:0];
    u = (k < 4'd8) ? x : y;
    v = (k < 4'd4) ? y : ((k == 4'd12 || k == 4'd14) ? x : z);
    return (k[0] ? -u : u) + (k[1] ? -v : v);
  endfunction

  logic                 en;
  logic                 wr_go;
  logic                 ev_go;
  logic                 v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, out_vld_q;

  logic [TblAw-1:0]     perm_q [NumCopies][TblDepth];
  logic [TblAw-1:0]     rd_q [2*NumCopies];
  logic [TblAw-1:0]     ra [2*NumCopies];

  logic [TblAw-1:0]     cell0 [3];
  logic signed [VW-1:0] t0 [3];
  logic [TblAw-1:0]     c1_q [3];
  logic [TblAw-1:0]     c2_q [3];
  logic signed [VW-1:0] t1_q [3], t2_q [3], t3_q [3];
  logic signed [VW-1:0] tt1_q [3], in1_q [3], cube2_q [3], in2_q [3];
  logic signed [VW-1:0] w3c [3];
  logic signed [VW-1:0] w3_q [3], w4_q [3], w5_q [3], w6_q [3];
  logic signed [VW-1:0] g4_q [8];
  logic signed [VW-1:0] n5_q [4];
  logic signed [VW-1:0] y6_q [2];
  logic signed [VW-1:0] rr;
  logic signed [31:0]   r32;
  logic [NoiseW-1:0]    sat;
  logic [NoiseW-1:0]    out_q;
  logic [TblAw-1:0]     ha, hb, haa, hab, hba, hbb;

  assign en          = !out_vld_q || out_ready_i;
  assign ev_go       = item_vld_i && (item_i.mode == MODE_EVAL) && en;
  assign wr_go       = item_vld_i && (item_i.mode == MODE_WRITE) && !v1_q && !v2_q;
  assign pop_o       = ev_go || wr_go;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cell0[k] = item_i.sum[k][FracBits+TblAw-1:FracBits];
      t0[k]    = $signed(VW'(item_i.sum[k][FracBits-1:0]));
    end
    ha  = rd_q[0] + c1_q[1];
    hb  = rd_q[1] + c1_q[1];
    haa = rd_q[2] + c2_q[2];
    hab = rd_q[3] + c2_q[2];
    hba = rd_q[4] + c2_q[2];
    hbb = rd_q[5] + c2_q[2];
    ra[0]  = cell0[0];
    ra[1]  = TblAw'(cell0[0] + 1'b1);
    ra[2]  = ha;
    ra[3]  = TblAw'(ha + 1'b1);
    ra[4]  = hb;
    ra[5]  = TblAw'(hb + 1'b1);
    ra[6]  = haa;
    ra[7]  = TblAw'(haa + 1'b1);
    ra[8]  = hab;
    ra[9]  = TblAw'(hab + 1'b1);
    ra[10] = hba;
    ra[11] = TblAw'(hba + 1'b1);
    ra[12] = hbb;
    ra[13] = TblAw'(hbb + 1'b1);
    for (int k = 0; k < 3; k++) begin
      w3c[k] = rmul(cube2_q[k], in2_q[k]);
      if (w3c[k] < 0) w3c[k] = '0;
      if (w3c[k] > OneV) w3c[k] = OneV;
    end
    rr  = blend(w6_q[2], y6_q[0], y6_q[1]);
    r32 = 32'(rr);
    if (r32 > NoiseMax) sat = NoiseW'(NoiseMax);
    else if (r32 < NoiseMin) sat = NoiseW'(NoiseMin);
    else sat = r32[NoiseW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (wr_go) begin
      for (int c = 0; c < NumCopies; c++) perm_q[c][item_i.tbl_idx] <= item_i.tbl_val;
    end
    if (en) begin
      for (int i = 0; i < 2 * NumCopies; i++) rd_q[i] <= perm_q[i>>1][ra[i]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      v5_q      <= 1'b0;
      v6_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      v1_q      <= ev_go;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      v4_q      <= v3_q;
      v5_q      <= v4_q;
      v6_q      <= v5_q;
      out_vld_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        c1_q[k]    <= cell0[k];
        c2_q[k]    <= c1_q[k];
        t1_q[k]    <= t0[k];
        t2_q[k]    <= t1_q[k];
        t3_q[k]    <= t2_q[k];
        tt1_q[k]   <= rmul(t0[k], t0[k]);
        in1_q[k]   <= rmul(t0[k], (t0[k] <<< 2) + (t0[k] <<< 1) - FifteenV) + TenV;
        cube2_q[k] <= rmul(tt1_q[k], t1_q[k]);
        in2_q[k]   <= in1_q[k];
        w3_q[k]    <= w3c[k];
        w4_q[k]    <= w3_q[k];
        w5_q[k]    <= w4_q[k];
        w6_q[k]    <= w5_q[k];
      end
      for (int j = 0; j < 8; j++) begin
        g4_q[j] <= grad(rd_q[6+j],
                        j[2] ? t3_q[0] - OneV : t3_q[0],
                        j[1] ? t3_q[1] - OneV : t3_q[1],
                        j[0] ? t3_q[2] - OneV : t3_q[2]);
      end
      for (int m = 0; m < 4; m++) n5_q[m] <= blend(w4_q[0], g4_q[m], g4_q[m+4]);
      y6_q[0] <= blend(w5_q[1], n5_q[0], n5_q[2]);
      y6_q[1] <= blend(w5_q[1], n5_q[1], n5_q[3]);
      out_q   <= sat;
    end
  end

endmodule
`default_nettype wire

// ===== design/improved_gradient_noise_3d_core.sv =====
// Top level of the 3D improved gradient noise core.
// Takes one beat per clock and gives one noise value per clock for evaluate beats, as long as
// m_axis_tready holds and no table write waits in the queue; an evaluate beat passes the front
// register, the queue and seven back-end stages (three permutation table read stages,
// gradients, three blend stages) on its way to the output. A table write beat gives no result
// and leaves the queue only once the first two table read stages hold no evaluation. The table is
// held in seven copies of 256 entries, each read at two addresses per cycle, all written together.
`default_nettype none
module improved_gradient_noise_3d_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [1:0]    cfg_index_i,
  input  wire logic [23:0]   cfg_data_i,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // table_index[7:0], table_value[15:8], coord_x[47:16], coord_y[79:48], coord_z[111:80]
  input  wire logic [111:0]  s_axis_tdata,
  // mode[0]
  input  wire logic          s_axis_tuser,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // noise_value[17:0], zero[23:18]
  output logic [23:0]        m_axis_tdata
);
  import ign3_pkg::*;

  item_t             front_item;
  logic              front_vld;
  logic              q_rdy;
  item_t             q_item;
  logic              q_vld;
  logic              q_pop;
  logic [NoiseW-1:0] noise;

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {6'b0, noise};

  ign3_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .s_user_i    (s_axis_tuser),
    .item_o      (front_item),
    .item_vld_o  (front_vld),
    .item_rdy_i  (q_rdy)
  );

  ign3_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (front_item),
    .in_vld_i   (front_vld),
    .in_rdy_o   (q_rdy),
    .out_item_o (q_item),
    .out_vld_o  (q_vld),
    .out_pop_i  (q_pop)
  );

  ign3_back #(
    .FracBits (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (q_item),
    .item_vld_i  (q_vld),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (noise)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_vld && !q_rdy |=> front_vld && $stable(front_item))
    else $error("front beat lost while queue full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_vld)
    else $error("queue popped while empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> front_vld)
    else $error("accepted beat not held in front register");

endmodule
`default_nettype wire
